// ===== src/grid_local_minimum_risk_sum_macros.svh =====
`ifndef GRID_LOCAL_MINIMUM_RISK_SUM_MACROS_SVH
`define GRID_LOCAL_MINIMUM_RISK_SUM_MACROS_SVH

// same-cycle implication, off during reset
`define GLMRS_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication, off during reset
`define GLMRS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ===== src/glmrs_pkg.sv =====
package glmrs_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 128;

  localparam int HEIGHT_W    = 4;
  localparam int RISK_W      = 18;
  localparam int SIZE_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int SIZE_RESET  = 128;

  localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  typedef logic [HEIGHT_W-1:0] height_t;

  typedef struct packed {
    logic             shift;
    logic [COL_W-1:0] entry;
  } line_ctrl_t;

endpackage

// ===== src/glmrs_in_if.sv =====
interface glmrs_in_if;
  logic                      valid;
  logic                      ready;
  logic [glmrs_pkg::HEIGHT_W-1:0] height_value;

  modport source (output valid, output height_value, input ready);
  modport sink (input valid, input height_value, output ready);
endinterface

// ===== src/glmrs_out_if.sv =====
interface glmrs_out_if;
  logic                    valid;
  logic                    ready;
  logic [glmrs_pkg::RISK_W-1:0] risk_total;

  modport source (output valid, output risk_total, input ready);
  modport sink (input valid, input risk_total, output ready);
endinterface

// ===== src/glmrs_cell.sv =====
module glmrs_cell (
  input  logic               clk,
  input  logic               shift,
  input  logic               load_new,
  input  glmrs_pkg::height_t new_value,
  input  glmrs_pkg::height_t prev_value,
  output glmrs_pkg::height_t value
);

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= load_new ? new_value : prev_value;
    end
  end

endmodule

// ===== src/glmrs_line.sv =====
module glmrs_line (
  input  logic                  clk,
  input  glmrs_pkg::line_ctrl_t ctrl,
  input  glmrs_pkg::height_t    feed,
  output glmrs_pkg::height_t    tail,
  output glmrs_pkg::height_t    near_tail
);

  glmrs_pkg::height_t value [glmrs_pkg::MAX_COLUMNS];

  for (genvar i = 0; i < glmrs_pkg::MAX_COLUMNS; i++) begin : g_cell
    glmrs_pkg::height_t prev;
    if (i == 0) begin : g_head
      assign prev = feed;
    end else begin : g_body
      assign prev = value[i-1];
    end
    glmrs_cell u_cell (
      .clk        (clk),
      .shift      (ctrl.shift),
      .load_new   (ctrl.entry == glmrs_pkg::COL_W'(i)),
      .new_value  (feed),
      .prev_value (prev),
      .value      (value[i])
    );
  end

  assign tail = value[glmrs_pkg::MAX_COLUMNS-1];

  if (glmrs_pkg::MAX_COLUMNS > 1) begin : g_near
    assign near_tail = value[glmrs_pkg::MAX_COLUMNS-2];
  end else begin : g_no_near
    assign near_tail = '0;
  end

endmodule

// ===== src/grid_local_minimum_risk_sum.sv =====
// Four-neighbour local minimum risk sum over a raster frame.
// pixel_in: one height per beat, raster order; frame size comes from the
// frame_width (index 0) and frame_height (index 1) registers. A write to
// either register restarts the frame; sizes of 0 act as 1, oversize values
// act as the maximum.
// total_out: one beat per frame carrying the risk total, registered and
// valid the cycle after the frame's last pixel is accepted.
// Throughput: one pixel per cycle. Every cell is decided while pixels
// stream, from two chains of cells that delay the stream by one and two
// rows, so no pass over the last row is needed after the frame ends.
// While a total waits, pixels keep flowing; only the next frame's last
// pixel is held off until the pending total is taken.
// Reset: positions and total cleared, both sizes set to 128; the delay
// chains need no clearing since a frame only reads what it has written.
module grid_local_minimum_risk_sum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [glmrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [glmrs_pkg::SIZE_W-1:0]         cfg_data,
  glmrs_in_if.sink                             pixel_in,
  glmrs_out_if.source                          total_out
);

  localparam int CONTRIB_W = glmrs_pkg::HEIGHT_W + 1;
  localparam int SUM_W     = glmrs_pkg::HEIGHT_W + 3;

  function automatic logic [glmrs_pkg::COL_CNT_W-1:0] clamp_cols(
    input logic [glmrs_pkg::SIZE_W-1:0] v);
    if (v == '0) return glmrs_pkg::COL_CNT_W'(1);
    else if (int'(v) > glmrs_pkg::MAX_COLUMNS) return glmrs_pkg::COL_CNT_W'(glmrs_pkg::MAX_COLUMNS);
    else return glmrs_pkg::COL_CNT_W'(v);
  endfunction

  function automatic logic [glmrs_pkg::ROW_CNT_W-1:0] clamp_rows(
    input logic [glmrs_pkg::SIZE_W-1:0] v);
    if (v == '0) return glmrs_pkg::ROW_CNT_W'(1);
    else if (int'(v) > glmrs_pkg::MAX_ROWS) return glmrs_pkg::ROW_CNT_W'(glmrs_pkg::MAX_ROWS);
    else return glmrs_pkg::ROW_CNT_W'(v);
  endfunction

  function automatic logic [CONTRIB_W-1:0] cell_risk(
    input glmrs_pkg::height_t center,
    input logic up_ok, input glmrs_pkg::height_t up,
    input logic down_ok, input glmrs_pkg::height_t down,
    input logic left_ok, input glmrs_pkg::height_t left,
    input logic right_ok, input glmrs_pkg::height_t right);
    logic lowest;
    lowest = (!up_ok || up > center) && (!down_ok || down > center) &&
             (!left_ok || left > center) && (!right_ok || right > center);
    return lowest ? CONTRIB_W'(center) + CONTRIB_W'(1) : '0;
  endfunction

  logic [glmrs_pkg::COL_CNT_W-1:0] width_cfg;
  logic [glmrs_pkg::ROW_CNT_W-1:0] height_cfg;
  logic [glmrs_pkg::COL_W-1:0]     col;
  logic [glmrs_pkg::ROW_W-1:0]     row;
  logic [glmrs_pkg::RISK_W-1:0]    acc;
  glmrs_pkg::height_t              p1;
  glmrs_pkg::height_t              p2;
  glmrs_pkg::height_t              left_above;
  logic                            out_valid;
  logic [glmrs_pkg::RISK_W-1:0]    out_data;

  glmrs_pkg::line_ctrl_t ctrl;
  glmrs_pkg::height_t    h;
  glmrs_pkg::height_t    a_tail;
  glmrs_pkg::height_t    a_near;
  glmrs_pkg::height_t    b_tail;

  logic                         beat;
  logic                         last_col;
  logic                         last_row;
  logic                         is_last;
  logic                         cfg_hit;
  logic                         frame_done;
  logic [CONTRIB_W-1:0]         risk_upper;
  logic [CONTRIB_W-1:0]         risk_left;
  logic [CONTRIB_W-1:0]         risk_here;
  logic [SUM_W-1:0]             risk_sum;
  logic [glmrs_pkg::RISK_W-1:0] total;

  assign h        = pixel_in.height_value;
  assign beat     = pixel_in.valid && pixel_in.ready;
  assign last_col = glmrs_pkg::COL_CNT_W'(col) + glmrs_pkg::COL_CNT_W'(1) == width_cfg;
  assign last_row = glmrs_pkg::ROW_CNT_W'(row) + glmrs_pkg::ROW_CNT_W'(1) == height_cfg;
  assign is_last  = last_col && last_row;

  assign cfg_hit    = cfg_write && (cfg_index == glmrs_pkg::REG_FRAME_WIDTH ||
                                    cfg_index == glmrs_pkg::REG_FRAME_HEIGHT);
  assign frame_done = beat && is_last && !cfg_hit;

  assign pixel_in.ready = !(out_valid && !total_out.ready && is_last);

  assign ctrl.shift = beat;
  assign ctrl.entry = glmrs_pkg::COL_W'(glmrs_pkg::COL_CNT_W'(glmrs_pkg::MAX_COLUMNS) - width_cfg);

  // a: one row behind the stream, b: two rows behind
  glmrs_line u_line_a (
    .clk       (clk),
    .ctrl      (ctrl),
    .feed      (h),
    .tail      (a_tail),
    .near_tail (a_near)
  );

  glmrs_line u_line_b (
    .clk       (clk),
    .ctrl      (ctrl),
    .feed      (a_tail),
    .tail      (b_tail),
    .near_tail ()
  );

  always_comb begin
    risk_upper = '0;
    risk_left  = '0;
    risk_here  = '0;
    if (int'(row) >= 1) begin
      risk_upper = cell_risk(a_tail, int'(row) >= 2, b_tail, 1'b1, h,
                             col != '0, left_above, !last_col, a_near);
    end
    if (last_row && col != '0) begin
      risk_left = cell_risk(p1, int'(height_cfg) >= 2, left_above, 1'b0, h,
                            int'(col) >= 2, p2, 1'b1, h);
    end
    if (is_last) begin
      risk_here = cell_risk(h, int'(height_cfg) >= 2, a_tail, 1'b0, h,
                            col != '0, p1, 1'b0, h);
    end
    risk_sum = SUM_W'(risk_upper) + SUM_W'(risk_left) + SUM_W'(risk_here);
    total    = acc + glmrs_pkg::RISK_W'(risk_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= clamp_cols(glmrs_pkg::SIZE_W'(glmrs_pkg::SIZE_RESET));
      height_cfg <= clamp_rows(glmrs_pkg::SIZE_W'(glmrs_pkg::SIZE_RESET));
      col        <= '0;
      row        <= '0;
      acc        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (frame_done) begin
        out_valid <= 1'b1;
      end else if (total_out.valid && total_out.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_hit) begin
        if (cfg_index == glmrs_pkg::REG_FRAME_WIDTH) begin
          width_cfg <= clamp_cols(cfg_data);
        end else begin
          height_cfg <= clamp_rows(cfg_data);
        end
        col <= '0;
        row <= '0;
        acc <= '0;
      end else if (beat) begin
        if (is_last) begin
          acc       <= '0;
          col       <= '0;
          row       <= '0;
        end else if (last_col) begin
          acc <= total;
          col <= '0;
          row <= row + glmrs_pkg::ROW_W'(1);
        end else begin
          acc <= total;
          col <= col + glmrs_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      p1         <= h;
      p2         <= p1;
      left_above <= a_tail;
    end
    if (frame_done) begin
      out_data <= total;
    end
  end

  assign total_out.valid      = out_valid;
  assign total_out.risk_total = out_data;

  `include "grid_local_minimum_risk_sum_macros.svh"

  `GLMRS_ASSERT_IMPLY(a_col_in_frame, clk, rst, 1'b1,
    glmrs_pkg::COL_CNT_W'(col) < width_cfg, "column beyond frame width")
  `GLMRS_ASSERT_IMPLY(a_row_in_frame, clk, rst, 1'b1,
    glmrs_pkg::ROW_CNT_W'(row) < height_cfg, "row beyond frame height")
  `GLMRS_ASSERT_IMPLY(a_total_from_last, clk, rst, $rose(out_valid),
    $past(beat && is_last), "total raised without a last pixel")
  `GLMRS_ASSERT_NEXT(a_clear_after_last, clk, rst, beat && is_last && !cfg_write,
    acc == '0 && col == '0 && row == '0, "frame state not cleared")

endmodule
